FILE: hw/rtl/half_duplex_uart_8n1_top_macros.svh
// Assertion macros shared by the UART RTL files.
`ifndef HALF_DUPLEX_UART_8N1_TOP_MACROS_SVH
`define HALF_DUPLEX_UART_8N1_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HDU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HDU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hdu_pkg.sv
// Types and constants shared by the half-duplex UART modules.
`timescale 1ns / 1ps
`default_nettype none
package hdu_pkg;

    localparam int DATA_BITS_DEF  = 8;
    localparam int TIMER_BITS_DEF = 8;

    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] BIT_PERIOD_RST  = 8'd53;
    localparam logic [CFG_W-1:0] START_DELAY_RST = 8'd80;

    localparam logic CFG_BIT_PERIOD  = 1'b0;
    localparam logic CFG_START_DELAY = 1'b1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SEND  = 2'd1,
        FUNC_ARM   = 2'd2,
        FUNC_RESET = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } t_mode;

    typedef struct packed {
        logic       tx_line;
        t_mode      mode;
        logic [7:0] rx_data;
        logic       rx_done;
        logic       tx_done;
        logic       refused;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/hdu_core.sv
// UART state registers and the per-item next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
`include "half_duplex_uart_8n1_top_macros.svh"
module hdu_core
    import hdu_pkg::*;
#(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [1:0]       i_func,
    input  wire logic [7:0]       i_tx_byte,
    input  wire logic             i_rx_line,
    input  wire logic [CFG_W-1:0] i_bit_period,
    input  wire logic [CFG_W-1:0] i_start_delay,
    output t_result               o_res
);

    localparam int BD_W   = $clog2(DATA_BITS + 2);
    localparam int DIDX_W = $clog2(DATA_BITS);
    localparam logic [BD_W-1:0] BD_DATA = BD_W'(DATA_BITS);
    localparam logic [BD_W-1:0] BD_LAST = BD_W'(DATA_BITS + 1);

    t_mode                  r_op_mode, n_op_mode;
    logic [BD_W-1:0]        r_bits_done, n_bits_done;
    logic [DATA_BITS-1:0]   r_rx_shift, n_rx_shift;
    logic [DATA_BITS-1:0]   r_tx_hold, n_tx_hold;
    logic [TIMER_BITS-1:0]  r_tick_count, n_tick_count;
    logic [TIMER_BITS-1:0]  r_tick_limit, n_tick_limit;
    logic                   r_timer_running, n_timer_running;
    logic                   r_edge_armed, n_edge_armed;
    logic                   r_rx_prev;
    logic                   r_tx_level, n_tx_level;

    t_func              func;
    logic               advance;
    logic               fall_edge;
    logic               rx_done;
    logic               tx_done;
    logic               refused;
    logic [DIDX_W-1:0]  bit_idx;

    assign func = t_func'(i_func);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode       <= MODE_IDLE;
            r_bits_done     <= '0;
            r_rx_shift      <= '0;
            r_tx_hold       <= '0;
            r_tick_count    <= '0;
            r_tick_limit    <= TIMER_BITS'(BIT_PERIOD_RST);
            r_timer_running <= 1'b0;
            r_edge_armed    <= 1'b0;
            r_rx_prev       <= 1'b1;
            r_tx_level      <= 1'b1;
        end else if (i_step) begin
            r_op_mode       <= n_op_mode;
            r_bits_done     <= n_bits_done;
            r_rx_shift      <= n_rx_shift;
            r_tx_hold       <= n_tx_hold;
            r_tick_count    <= n_tick_count;
            r_tick_limit    <= n_tick_limit;
            r_timer_running <= n_timer_running;
            r_edge_armed    <= n_edge_armed;
            r_rx_prev       <= i_rx_line;
            r_tx_level      <= n_tx_level;
        end
    end

    always_comb begin
        n_op_mode       = r_op_mode;
        n_bits_done     = r_bits_done;
        n_rx_shift      = r_rx_shift;
        n_tx_hold       = r_tx_hold;
        n_tick_count    = r_tick_count;
        n_tick_limit    = r_tick_limit;
        n_timer_running = r_timer_running;
        n_edge_armed    = r_edge_armed;
        n_tx_level      = r_tx_level;
        advance         = 1'b1;
        rx_done         = 1'b0;
        tx_done         = 1'b0;
        refused         = 1'b0;
        fall_edge       = r_edge_armed && r_rx_prev && !i_rx_line;

        if (func == FUNC_RESET) begin
            n_op_mode       = MODE_IDLE;
            n_bits_done     = '0;
            n_rx_shift      = '0;
            n_tx_hold       = '0;
            n_tick_count    = '0;
            n_timer_running = 1'b0;
            n_edge_armed    = 1'b0;
            n_tx_level      = 1'b1;
            advance         = 1'b0;
        end else begin
            if (fall_edge) begin
                n_edge_armed    = 1'b0;
                n_tick_count    = '0;
                n_tick_limit    = TIMER_BITS'(i_start_delay);
                n_timer_running = 1'b1;
                advance         = 1'b0;
            end
            if (func == FUNC_SEND || func == FUNC_ARM) begin
                if (r_op_mode != MODE_IDLE) begin
                    refused = 1'b1;
                end else if (func == FUNC_SEND) begin
                    n_op_mode       = MODE_TX;
                    n_bits_done     = '0;
                    n_tx_hold       = DATA_BITS'(i_tx_byte);
                    n_tx_level      = 1'b0;
                    n_tick_count    = '0;
                    n_tick_limit    = TIMER_BITS'(i_bit_period);
                    n_timer_running = 1'b1;
                    advance         = 1'b0;
                end else begin
                    n_op_mode    = MODE_RX;
                    n_bits_done  = '0;
                    n_rx_shift   = '0;
                    n_edge_armed = 1'b1;
                end
            end
        end

        bit_idx = n_bits_done[DIDX_W-1:0];

        if (advance && n_timer_running) begin
            if (n_tick_count != n_tick_limit) begin
                n_tick_count = n_tick_count + TIMER_BITS'(1);
            end else begin
                n_tick_count = '0;
                case (n_op_mode)
                    MODE_RX: begin
                        if (n_bits_done >= BD_DATA) begin
                            n_timer_running = 1'b0;
                            n_op_mode       = MODE_IDLE;
                            rx_done         = 1'b1;
                        end else begin
                            n_rx_shift[bit_idx] = n_rx_shift[bit_idx] | i_rx_line;
                            n_bits_done         = n_bits_done + BD_W'(1);
                            n_tick_limit        = TIMER_BITS'(i_bit_period);
                            n_timer_running     = 1'b1;
                        end
                    end
                    MODE_TX: begin
                        if (n_bits_done < BD_DATA) begin
                            n_tx_level  = n_tx_hold[bit_idx];
                            n_bits_done = n_bits_done + BD_W'(1);
                        end else if (n_bits_done == BD_DATA) begin
                            n_tx_level  = 1'b1;
                            n_bits_done = n_bits_done + BD_W'(1);
                        end else begin
                            n_timer_running = 1'b0;
                            n_op_mode       = MODE_IDLE;
                            tx_done         = 1'b1;
                        end
                    end
                    default: begin
                        n_timer_running = 1'b0;
                        n_op_mode       = MODE_IDLE;
                    end
                endcase
            end
        end

        o_res.tx_line = n_tx_level;
        o_res.mode    = n_op_mode;
        o_res.rx_data = 8'(n_rx_shift);
        o_res.rx_done = rx_done;
        o_res.tx_done = tx_done;
        o_res.refused = refused;
    end

    `HDU_ASSERT_IMP(a_tx_idle_high, i_clk, i_rst_n, r_op_mode != MODE_TX, r_tx_level, "tx line low outside transmit")
    `HDU_ASSERT_IMP(a_tx_timer, i_clk, i_rst_n, r_op_mode == MODE_TX, r_timer_running, "timer stopped during transmit")
    `HDU_ASSERT_IMP(a_rx_progress, i_clk, i_rst_n, r_op_mode == MODE_RX, r_edge_armed || r_timer_running, "receive neither armed nor timing")
    `HDU_ASSERT_IMP(a_armed_rx, i_clk, i_rst_n, r_edge_armed, r_op_mode == MODE_RX, "edge detector armed outside receive")
    `HDU_ASSERT_IMP(a_bits_range, i_clk, i_rst_n, 1'b1, r_bits_done <= BD_LAST, "bit counter out of range")

endmodule
`default_nettype wire

FILE: hw/rtl/half_duplex_uart_8n1_top.sv
// Top level of the half-duplex 8N1 UART: config registers, core and result buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "half_duplex_uart_8n1_top_macros.svh"
// Every accepted item is one timer tick, optionally carrying a send, arm or reset
// command; a reset, an accepted send or a detected start edge does not tick. Each
// item yields exactly one result, in the output register or, while it stalls, the
// skid register. The block takes one item per clock cycle: the per-item update is
// a single pass through the core's next-state logic, and the two-entry result
// buffer keeps accepting while a result waits, so o_in_ready falls only when both
// entries hold unconsumed results. Config writes apply at the next timer reload.
module half_duplex_uart_8n1_top
    import hdu_pkg::*;
#(
    parameter int DATA_BITS  = DATA_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [1:0]       i_func,
    input  wire logic [7:0]       i_tx_byte,
    input  wire logic             i_rx_line,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic                  o_tx_line,
    output logic [1:0]            o_mode,
    output logic [7:0]            o_rx_data,
    output logic                  o_rx_done,
    output logic                  o_tx_done,
    output logic                  o_refused
);

    logic [CFG_W-1:0] r_bit_period;
    logic [CFG_W-1:0] r_start_delay;
    t_result          r_out, n_out;
    t_result          r_skid, n_skid;
    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    t_result          step_res;
    logic             in_fire;
    logic             out_fire;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= BIT_PERIOD_RST;
            r_start_delay <= START_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIT_PERIOD:  r_bit_period  <= i_cfg_data;
                CFG_START_DELAY: r_start_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hdu_core #(
        .DATA_BITS  (DATA_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_fire),
        .i_func        (i_func),
        .i_tx_byte     (i_tx_byte),
        .i_rx_line     (i_rx_line),
        .i_bit_period  (r_bit_period),
        .i_start_delay (r_start_delay),
        .o_res         (step_res)
    );

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = step_res;
                n_out_valid = in_fire;
            end
        end else if (in_fire) begin
            n_skid       = step_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_line   = r_out.tx_line;
    assign o_mode      = r_out.mode;
    assign o_rx_data   = r_out.rx_data;
    assign o_rx_done   = r_out.rx_done;
    assign o_tx_done   = r_out.tx_done;
    assign o_refused   = r_out.refused;

    `HDU_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry without output entry")
    `HDU_ASSERT_NXT(a_skid_catch, i_clk, i_rst_n, in_fire && r_out_valid && !i_out_ready, r_skid_valid, "item lost while output stalled")
    `HDU_ASSERT_NXT(a_cfg_period, i_clk, i_rst_n, i_cfg_we && i_cfg_idx == CFG_BIT_PERIOD, r_bit_period == $past(i_cfg_data), "bit period write not taken")

endmodule
`default_nettype wire
